### rtl/core/float_multiplier_mixed_format_unit_assert.svh
// assertion macros used by the checker file
// depends on nothing; include guarded
`ifndef FLOAT_MULTIPLIER_MIXED_FORMAT_UNIT_ASSERT_SVH
`define FLOAT_MULTIPLIER_MIXED_FORMAT_UNIT_ASSERT_SVH

// implication checked on the next clock edge, skipped in reset
`define FMMF_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

// implication checked in the same cycle, skipped in reset
`define FMMF_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// implication checked on the next clock edge, also active in reset
`define FMMF_ASSERT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/core/fmmf_pkg.sv
// formats, widths, types and helpers of the mixed format float multiplier
// used by the top level and its checker; depends on nothing
`timescale 1ns / 1ps

package fmmf_pkg;

    // operand formats
    localparam int EXP_BITS_X = 8;
    localparam int MAN_BITS_X = 23;
    localparam int EXP_BITS_Y = 8;
    localparam int MAN_BITS_Y = 23;

    // result format takes the wider of each field
    localparam int RES_EXP_BITS = (EXP_BITS_X > EXP_BITS_Y) ? EXP_BITS_X : EXP_BITS_Y;
    localparam int RES_MAN_BITS = (MAN_BITS_X > MAN_BITS_Y) ? MAN_BITS_X : MAN_BITS_Y;

    localparam int BIAS_X = (1 << (EXP_BITS_X - 1)) - 1;
    localparam int BIAS_Y = (1 << (EXP_BITS_Y - 1)) - 1;
    localparam int BIAS_R = (1 << (RES_EXP_BITS - 1)) - 1;

    // significands are left aligned in a common width before the multiply
    localparam int SIG_W = RES_MAN_BITS + 1;
    localparam int LZ_W  = $clog2(SIG_W + 1);
    localparam int PROD_W = 2 * SIG_W;
    localparam int EB_W  = RES_EXP_BITS + $clog2(SIG_W) + 4;
    localparam int DROP_MAX = PROD_W + 1;
    localparam int DROP_W = $clog2(DROP_MAX + 1);
    localparam int Q_W = RES_MAN_BITS + 2;

    localparam logic [RES_EXP_BITS-1:0] RES_EXP_MAX = {RES_EXP_BITS{1'b1}};

    // rounding modes
    localparam logic [1:0] RM_UP   = 2'd0;
    localparam logic [1:0] RM_DOWN = 2'd1;
    localparam logic [1:0] RM_ZERO = 2'd2;
    localparam logic [1:0] RM_EVEN = 2'd3;

    typedef enum logic [1:0] {
        KIND_NUM,
        KIND_NAN,
        KIND_INF,
        KIND_ZERO
    } kind_t;

    // leading zero count of a significand
    function automatic logic [LZ_W-1:0] lzc(input logic [SIG_W-1:0] v);
        logic [LZ_W-1:0] n;
        logic            hit;
        n   = LZ_W'(SIG_W);
        hit = 1'b0;
        for (int i = SIG_W - 1; i >= 0; i--) begin
            if (!hit && v[i]) begin
                n   = LZ_W'(SIG_W - 1 - i);
                hit = 1'b1;
            end
        end
        return n;
    endfunction

endpackage

### rtl/core/float_multiplier_mixed_format_unit.sv
// mixed format float multiplier, four stage pipeline
// depends on fmmf_pkg
`timescale 1ns / 1ps

//  channel   signals                                   handshake
//  input     s_x_*, s_y_*                              s_valid / s_ready
//  result    m_prod_sign, m_prod_exp, m_prod_man       m_valid / m_ready
//  config    cfg_we, cfg_wdata (rounding mode)         write enable only
//
// one word per cycle from input word to result word while the output register is free or taken
// stage 1 decodes and normalizes operands, stage 2 is the 24x24 multiplier,
// stage 3 is the alignment shifter, stage 4 rounds into the output register
// all stages advance together whenever the output register is free or taken
// reset clears the stage valid bits and sets round to nearest even

module float_multiplier_mixed_format_unit
    import fmmf_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_we,
    input  logic [1:0]              cfg_wdata,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_x_sign,
    input  logic [EXP_BITS_X-1:0]   s_x_exp,
    input  logic [MAN_BITS_X-1:0]   s_x_man,
    input  logic                    s_y_sign,
    input  logic [EXP_BITS_Y-1:0]   s_y_exp,
    input  logic [MAN_BITS_Y-1:0]   s_y_man,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic                    m_prod_sign,
    output logic [RES_EXP_BITS-1:0] m_prod_exp,
    output logic [RES_MAN_BITS-1:0] m_prod_man
);

    logic [1:0] rm_reg;
    logic       adv;

    logic                    v1_reg, v2_reg, v3_reg, vo_reg;
    logic                    s1_reg, s2_reg, s3_reg;
    kind_t                   k1_reg, k2_reg, k3_reg;
    logic [SIG_W-1:0]        mx1_reg, my1_reg;
    logic signed [EB_W-1:0]  eb1_reg, eb2_reg;
    logic [PROD_W-1:0]       p2_reg;
    logic [Q_W-1:0]          q3_reg;
    logic                    g3_reg, t3_reg;
    logic signed [EB_W-1:0]  be3_reg;
    logic                    so_reg;
    logic [RES_EXP_BITS-1:0] eo_reg;
    logic [RES_MAN_BITS-1:0] mo_reg;

    // whole pipeline moves when the output word is free or taken
    assign adv     = !vo_reg || m_ready;
    assign s_ready = adv;

    // rounding mode register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rm_reg <= RM_EVEN;
        end else if (cfg_we) begin
            rm_reg <= cfg_wdata;
        end
    end

    // stage 1: classify operands, left align significands
    logic                   xnan, ynan, xinf, yinf, xzero, yzero;
    logic [SIG_W-1:0]       xsig, ysig, mx_next, my_next;
    logic [LZ_W-1:0]        lzx, lzy;
    logic signed [EB_W-1:0] fx, fy, eb1_next;
    kind_t                  k1_next;

    always_comb begin
        xnan  = (s_x_exp == {EXP_BITS_X{1'b1}}) && (s_x_man != '0);
        ynan  = (s_y_exp == {EXP_BITS_Y{1'b1}}) && (s_y_man != '0);
        xinf  = (s_x_exp == {EXP_BITS_X{1'b1}}) && (s_x_man == '0);
        yinf  = (s_y_exp == {EXP_BITS_Y{1'b1}}) && (s_y_man == '0);
        xzero = (s_x_exp == '0) && (s_x_man == '0);
        yzero = (s_y_exp == '0) && (s_y_man == '0);
        if (xnan || ynan || (xinf && yzero) || (xzero && yinf)) begin
            k1_next = KIND_NAN;
        end else if (xinf || yinf) begin
            k1_next = KIND_INF;
        end else if (xzero || yzero) begin
            k1_next = KIND_ZERO;
        end else begin
            k1_next = KIND_NUM;
        end
        xsig = SIG_W'({(s_x_exp != '0), s_x_man}) << (SIG_W - MAN_BITS_X - 1);
        ysig = SIG_W'({(s_y_exp != '0), s_y_man}) << (SIG_W - MAN_BITS_Y - 1);
        lzx  = lzc(xsig);
        lzy  = lzc(ysig);
        mx_next = xsig << lzx;
        my_next = ysig << lzy;
        // scale of each aligned significand: value = sig * 2^f
        fx = EB_W'((s_x_exp != '0) ? s_x_exp : EXP_BITS_X'(1))
           - EB_W'(lzx) - EB_W'(SIG_W - 1 + BIAS_X);
        fy = EB_W'((s_y_exp != '0) ? s_y_exp : EXP_BITS_Y'(1))
           - EB_W'(lzy) - EB_W'(SIG_W - 1 + BIAS_Y);
        eb1_next = fx + fy + EB_W'(BIAS_R);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_reg  <= s_x_sign ^ s_y_sign;
            k1_reg  <= k1_next;
            mx1_reg <= mx_next;
            my1_reg <= my_next;
            eb1_reg <= eb1_next;
        end
    end

    // stage 2: significand multiply
    always_ff @(posedge aclk) begin
        if (adv) begin
            s2_reg  <= s1_reg;
            k2_reg  <= k1_reg;
            p2_reg  <= mx1_reg * my1_reg;
            eb2_reg <= eb1_reg;
        end
    end

    // stage 3: exponent and right shift into result precision
    logic                   h3;
    logic signed [EB_W-1:0] be3_next, drop_full;
    logic [DROP_W-1:0]      drop;
    logic [2*PROD_W-1:0]    ext;

    always_comb begin
        h3 = p2_reg[PROD_W-1];
        be3_next = eb2_reg + EB_W'(PROD_W - 2) + EB_W'(h3);
        drop_full = ((be3_next >= EB_W'(1)) ? be3_next : EB_W'(1))
                  - eb2_reg - EB_W'(RES_MAN_BITS);
        drop = (drop_full > EB_W'(DROP_MAX)) ? DROP_W'(DROP_MAX) : DROP_W'(drop_full);
        ext = {p2_reg, {PROD_W{1'b0}}} >> drop;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s3_reg  <= s2_reg;
            k3_reg  <= k2_reg;
            be3_reg <= be3_next;
            q3_reg  <= ext[PROD_W+Q_W-1:PROD_W];
            g3_reg  <= ext[PROD_W-1];
            t3_reg  <= |ext[PROD_W-2:0];
        end
    end

    // stage 4: round, renormalize, overflow and special words
    logic                    inc;
    logic [Q_W-1:0]          q1;
    logic signed [EB_W-1:0]  bef;
    logic [RES_MAN_BITS-1:0] manf;
    logic [RES_EXP_BITS-1:0] eo_next;
    logic [RES_MAN_BITS-1:0] mo_next;

    always_comb begin
        case (rm_reg)
            RM_UP:   inc = !s3_reg && (g3_reg || t3_reg);
            RM_DOWN: inc = s3_reg && (g3_reg || t3_reg);
            RM_ZERO: inc = 1'b0;
            default: inc = g3_reg && (t3_reg || q3_reg[0]);
        endcase
        q1 = q3_reg + Q_W'(inc);
        if (be3_reg >= EB_W'(1)) begin
            if (q1[Q_W-1]) begin
                bef  = be3_reg + EB_W'(1);
                manf = q1[RES_MAN_BITS:1];
            end else begin
                bef  = be3_reg;
                manf = q1[RES_MAN_BITS-1:0];
            end
        end else begin
            bef  = EB_W'(q1[RES_MAN_BITS]);
            manf = q1[RES_MAN_BITS-1:0];
        end
        case (k3_reg)
            KIND_NAN: begin
                eo_next = RES_EXP_MAX;
                mo_next = RES_MAN_BITS'(1);
            end
            KIND_INF: begin
                eo_next = RES_EXP_MAX;
                mo_next = '0;
            end
            KIND_ZERO: begin
                eo_next = '0;
                mo_next = '0;
            end
            default: begin
                if (bef >= EB_W'({1'b0, RES_EXP_MAX})) begin
                    eo_next = RES_EXP_MAX;
                    mo_next = '0;
                end else begin
                    eo_next = bef[RES_EXP_BITS-1:0];
                    mo_next = manf;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            so_reg <= s3_reg;
            eo_reg <= eo_next;
            mo_reg <= mo_next;
        end
    end

    // valid bits travel with the words
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            vo_reg <= v3_reg;
        end
    end

    assign m_valid     = vo_reg;
    assign m_prod_sign = so_reg;
    assign m_prod_exp  = eo_reg;
    assign m_prod_man  = mo_reg;

endmodule

### rtl/core/fmmf_checker.sv
// port level checks of the mixed format float multiplier, bound to the top
// depends on fmmf_pkg and float_multiplier_mixed_format_unit_assert.svh
`timescale 1ns / 1ps
`include "float_multiplier_mixed_format_unit_assert.svh"

module fmmf_checker
    import fmmf_pkg::*;
(
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    s_ready,
    input logic                    m_valid,
    input logic                    m_ready,
    input logic [RES_EXP_BITS-1:0] m_prod_exp,
    input logic [RES_MAN_BITS-1:0] m_prod_man
);

    // a stalled result word stays valid and its significand holds
    `FMMF_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_prod_man))

    // input taken exactly when the output register can move
    `FMMF_ASSERT_NOW(a_ready, aclk, aresetn, 1'b1, s_ready == (!m_valid || m_ready))

    // all ones exponent carries only infinity or the single nan payload
    `FMMF_ASSERT_NOW(a_special, aclk, aresetn, m_valid && (m_prod_exp == RES_EXP_MAX), m_prod_man == RES_MAN_BITS'(0) || m_prod_man == RES_MAN_BITS'(1))

    // reset empties the pipeline
    `FMMF_ASSERT_ALWAYS(a_reset, aclk, !aresetn, !m_valid)

endmodule

bind float_multiplier_mixed_format_unit fmmf_checker u_fmmf_checker (.*);

### tb/float_multiplier_mixed_format_unit_tb.sv
// self-checking testbench for the mixed format float multiplier
// depends on fmmf_pkg and float_multiplier_mixed_format_unit
`timescale 1ns / 1ps

module float_multiplier_mixed_format_unit_tb;
    import fmmf_pkg::*;

    typedef struct {
        logic                  x_sign;
        logic [EXP_BITS_X-1:0] x_exp;
        logic [MAN_BITS_X-1:0] x_man;
        logic                  y_sign;
        logic [EXP_BITS_Y-1:0] y_exp;
        logic [MAN_BITS_Y-1:0] y_man;
    } operands_t;

    typedef struct {
        logic                    sign;
        logic [RES_EXP_BITS-1:0] exp;
        logic [RES_MAN_BITS-1:0] man;
    } product_t;

    logic                    aclk;
    logic                    aresetn;
    logic                    cfg_we;
    logic [1:0]              cfg_wdata;
    logic                    s_valid;
    logic                    s_ready;
    logic                    s_x_sign;
    logic [EXP_BITS_X-1:0]   s_x_exp;
    logic [MAN_BITS_X-1:0]   s_x_man;
    logic                    s_y_sign;
    logic [EXP_BITS_Y-1:0]   s_y_exp;
    logic [MAN_BITS_Y-1:0]   s_y_man;
    logic                    m_valid;
    logic                    m_ready;
    logic                    m_prod_sign;
    logic [RES_EXP_BITS-1:0] m_prod_exp;
    logic [RES_MAN_BITS-1:0] m_prod_man;

    operands_t pending_ops[$];
    product_t  expected_products[$];
    logic [1:0] round_mode;
    int        error_count;
    int        words_sent;
    int        words_seen;
    int        hold_left;
    bit        long_hold_done;

    float_multiplier_mixed_format_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_x_sign    (s_x_sign),
        .s_x_exp     (s_x_exp),
        .s_x_man     (s_x_man),
        .s_y_sign    (s_y_sign),
        .s_y_exp     (s_y_exp),
        .s_y_man     (s_y_man),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_prod_sign (m_prod_sign),
        .m_prod_exp  (m_prod_exp),
        .m_prod_man  (m_prod_man)
    );

    // clock
    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // exact product, normalized and rounded once into the wider format
    function automatic product_t multiply_round(operands_t op, logic [1:0] mode);
        product_t    r;
        logic        xnan, ynan, xinf, yinf, xzero, yzero, g, t, inc;
        logic [63:0] mx, my, p, q;
        longint      e, be, drop, bias_r;
        int          lead;
        r.sign = op.x_sign ^ op.y_sign;
        xnan  = (op.x_exp == '1) && (op.x_man != 0);
        ynan  = (op.y_exp == '1) && (op.y_man != 0);
        xinf  = (op.x_exp == '1) && (op.x_man == 0);
        yinf  = (op.y_exp == '1) && (op.y_man == 0);
        xzero = (op.x_exp == 0) && (op.x_man == 0);
        yzero = (op.y_exp == 0) && (op.y_man == 0);
        if (xnan || ynan || (xinf && yzero) || (xzero && yinf)) begin
            r.exp = RES_EXP_MAX;
            r.man = 1;
            return r;
        end
        if (xinf || yinf) begin
            r.exp = RES_EXP_MAX;
            r.man = 0;
            return r;
        end
        if (xzero || yzero) begin
            r.exp = 0;
            r.man = 0;
            return r;
        end
        mx = {40'd0, op.x_exp != 0, op.x_man};
        my = {40'd0, op.y_exp != 0, op.y_man};
        if (MAN_BITS_X != 23 || MAN_BITS_Y != 23) begin
            mx = (op.x_exp != 0 ? (64'd1 << MAN_BITS_X) : 64'd0) | 64'(op.x_man);
            my = (op.y_exp != 0 ? (64'd1 << MAN_BITS_Y) : 64'd0) | 64'(op.y_man);
        end
        p = mx * my;
        lead = 0;
        for (int i = 0; i < 64; i++)
            if (p[i]) lead = i;
        // value is p times two to the power e
        e = longint'(op.x_exp != 0 ? op.x_exp : 1) - BIAS_X
          + longint'(op.y_exp != 0 ? op.y_exp : 1) - BIAS_Y
          - MAN_BITS_X - MAN_BITS_Y;
        bias_r = BIAS_R;
        be = e + lead + bias_r;
        drop = (be >= 1 ? be : 1) - bias_r - RES_MAN_BITS - e;
        if (drop <= 0) begin
            q = p << (-drop);
            g = 0;
            t = 0;
        end else if (drop > 64) begin
            q = 0;
            g = 0;
            t = 1;
        end else begin
            q = (drop >= 64) ? 64'd0 : (p >> drop);
            g = p[drop-1];
            t = (p & ((64'd1 << (drop - 1)) - 64'd1)) != 0;
        end
        case (mode)
            RM_UP:   inc = !r.sign && (g || t);
            RM_DOWN: inc = r.sign && (g || t);
            RM_ZERO: inc = 1'b0;
            default: inc = g && (t || q[0]);
        endcase
        q = q + 64'(inc);
        // carry out of the significand, or subnormal reaching the normal range
        if (be >= 1) begin
            if ((q >> (RES_MAN_BITS + 1)) != 0) begin
                q = q >> 1;
                be++;
            end
        end else begin
            be = longint'(q[RES_MAN_BITS]);
        end
        if (be >= longint'(RES_EXP_MAX)) begin
            r.exp = RES_EXP_MAX;
            r.man = 0;
        end else begin
            r.exp = be[RES_EXP_BITS-1:0];
            r.man = q[RES_MAN_BITS-1:0];
        end
        return r;
    endfunction

    // driver: offers queued words, predicts each accepted one
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                operands_t cur;
                cur.x_sign = s_x_sign;
                cur.x_exp  = s_x_exp;
                cur.x_man  = s_x_man;
                cur.y_sign = s_y_sign;
                cur.y_exp  = s_y_exp;
                cur.y_man  = s_y_man;
                expected_products.push_back(multiply_round(cur, round_mode));
                words_sent++;
            end
            if (!s_valid || s_ready) begin
                if (pending_ops.size() > 0 &&
                    ((words_sent > 600 && words_sent < 850) || $urandom_range(99) >= 6)) begin
                    operands_t nxt;
                    nxt = pending_ops.pop_front();
                    s_x_sign <= nxt.x_sign;
                    s_x_exp  <= nxt.x_exp;
                    s_x_man  <= nxt.x_man;
                    s_y_sign <= nxt.y_sign;
                    s_y_exp  <= nxt.y_exp;
                    s_y_man  <= nxt.y_man;
                    s_valid  <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each result word, throttles m_ready
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                words_seen++;
                if (expected_products.size() == 0) begin
                    $error("unexpected result word: sign %0d exp %0d man %0h",
                           m_prod_sign, m_prod_exp, m_prod_man);
                    error_count++;
                end else begin
                    product_t want;
                    want = expected_products.pop_front();
                    if (m_prod_sign !== want.sign) begin
                        $error("prod_sign expected %0d actual %0d", want.sign, m_prod_sign);
                        error_count++;
                    end
                    if (m_prod_exp !== want.exp) begin
                        $error("prod_exp expected %0d actual %0d", want.exp, m_prod_exp);
                        error_count++;
                    end
                    if (m_prod_man !== want.man) begin
                        $error("prod_man expected %0h actual %0h", want.man, m_prod_man);
                        error_count++;
                    end
                end
            end
            // one long hold so the pipeline fills and backs up
            if (!long_hold_done && words_seen >= 300) begin
                long_hold_done = 1'b1;
                hold_left = 60;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= (words_seen > 600 && words_seen < 850) || $urandom_range(99) >= 6;
            end
        end
    end

    // random exponent, biased toward the interesting ranges
    function automatic logic [7:0] pick_exp();
        case ($urandom_range(9))
            0:       return 8'd0;
            1:       return 8'hff;
            2:       return 8'd1;
            3:       return 8'hfe;
            4:       return 8'($urandom_range(20, 90));
            5:       return 8'($urandom_range(170, 240));
            6:       return 8'($urandom);
            default: return 8'($urandom_range(100, 154));
        endcase
    endfunction

    function automatic logic [22:0] pick_man();
        case ($urandom_range(9))
            0:       return 23'd0;
            1:       return '1;
            2:       return 23'd1;
            default: return 23'($urandom);
        endcase
    endfunction

    task automatic queue_op(logic xs, logic [7:0] xe, logic [22:0] xm,
                            logic ys, logic [7:0] ye, logic [22:0] ym);
        operands_t op;
        op.x_sign = xs;
        op.x_exp  = xe;
        op.x_man  = xm;
        op.y_sign = ys;
        op.y_exp  = ye;
        op.y_man  = ym;
        pending_ops.push_back(op);
    endtask

    // wait until every word is checked and the pipeline is empty
    task automatic drain();
        while (pending_ops.size() > 0 || s_valid || expected_products.size() > 0)
            @(negedge aclk);
        repeat (10) @(negedge aclk);
    endtask

    task automatic set_round_mode(logic [1:0] mode);
        @(posedge aclk);
        cfg_we     <= 1'b1;
        cfg_wdata  <= mode;
        round_mode = mode;
        @(posedge aclk);
        cfg_we     <= 1'b0;
    endtask

    logic [1:0] mode_order[8] = '{RM_UP, RM_DOWN, RM_ZERO, RM_EVEN,
                                  RM_DOWN, RM_UP, RM_ZERO, RM_EVEN};

    // stimulus
    initial begin
        aresetn     = 1'b0;
        cfg_we      = 1'b0;
        cfg_wdata   = '0;
        s_valid     = 1'b0;
        s_x_sign    = 1'b0;
        s_x_exp     = '0;
        s_x_man     = '0;
        s_y_sign    = 1'b0;
        s_y_exp     = '0;
        s_y_man     = '0;
        m_ready     = 1'b0;
        round_mode  = RM_EVEN;
        error_count = 0;
        words_sent  = 0;
        words_seen  = 0;
        hold_left   = 0;
        long_hold_done = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed words under the reset rounding mode
        queue_op(0, 8'd127, 0, 0, 8'd127, 0);             // one times one
        queue_op(0, 8'd0, 0, 1, 8'd0, 0);                 // zero times zero
        queue_op(1, 8'hff, 0, 0, 8'd0, 0);                // infinity times zero
        queue_op(0, 8'd0, 0, 1, 8'hff, 0);                // zero times infinity
        queue_op(0, 8'hff, 23'd5, 0, 8'd127, 0);          // nan operand
        queue_op(1, 8'd10, 23'd3, 1, 8'hff, '1);          // nan in second operand
        queue_op(1, 8'hff, 0, 0, 8'hfe, '1);              // infinity times finite
        queue_op(0, 8'd0, 23'd9, 1, 8'd50, 0);            // subnormal times small normal
        queue_op(0, 8'hfe, '1, 0, 8'hfe, '1);             // overflow
        queue_op(1, 8'hfe, '1, 0, 8'd128, 0);             // overflow, largest finite doubled
        queue_op(0, 8'd0, 23'd1, 0, 8'd0, 23'd1);         // far underflow
        queue_op(1, 8'd0, 23'd1, 0, 8'd127, 0);           // min subnormal times one
        queue_op(0, 8'd1, 0, 0, 8'd126, 0);               // min normal halved to subnormal
        queue_op(0, 8'd0, '1, 0, 8'd127, 23'd2);          // subnormal times just over one, product normal
        queue_op(0, 8'd127, 23'd1, 0, 8'd127, 23'h400000); // exact tie
        queue_op(1, 8'd127, 23'd3, 0, 8'd127, 23'h400000); // tie, even lower neighbor
        queue_op(0, 8'd127, '1, 0, 8'd127, '1);           // significand carry
        queue_op(1, 8'd1, '1, 1, 8'd1, '1);               // deep underflow, nonzero
        queue_op(0, 8'd64, 23'h2aaaaa, 1, 8'd63, 23'h555555); // near subnormal edge
        queue_op(1, '1, 0, 1, '1, 0);                     // infinity times infinity
        drain();

        // random words across all rounding modes
        foreach (mode_order[k]) begin
            set_round_mode(mode_order[k]);
            for (int i = 0; i < 160; i++)
                queue_op(1'($urandom), pick_exp(), pick_man(),
                         1'($urandom), pick_exp(), pick_man());
            drain();
        end

        if (error_count == 0) begin
            $display("float_multiplier_mixed_format_unit_tb: PASS");
        end else begin
            $display("float_multiplier_mixed_format_unit_tb: FAIL");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5ms;
        $display("float_multiplier_mixed_format_unit_tb: FAIL");
        $finish;
    end

endmodule
